/* rtl/rtk_pkg.sv */
// ----------------------------------------------------------------------------
// RTC tick keeper package
// Shared widths, action codes, constant reciprocals and the stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package rtk_pkg;

    localparam int TICKS_W    = 32;
    localparam int SAMPLE_W   = 24;
    localparam int HOURS_W    = 5;
    localparam int MINUTES_W  = 6;
    localparam int SECONDS_W  = 6;
    localparam int COMP_W     = 8;
    localparam int TOTAL_W    = 21;
    localparam int TICK_SHIFT = 11;
    localparam int SECS_W     = TICKS_W - TICK_SHIFT;

    localparam logic [COMP_W-1:0] COMP_RESET = 8'd4;

    // Largest loaded second count is 31*3600 + 63*60 + 63 + 255.
    localparam int SYNC_SECS_W   = 17;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // Action codes.
    localparam logic ACT_SYNC   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Division by constants through exact reciprocals over a 21-bit second
    // count. Each divisor is split into a power of two (pre-shift) and an
    // odd part handled by multiply and post-shift.
    localparam int HOUR_PRE   = 4;          // 3600 = 16 * 225
    localparam int HOUR_POST  = 26;
    localparam int HOUR_RCP_W = 19;
    localparam logic [HOUR_RCP_W-1:0] HOUR_RCP = 19'd298263;

    localparam int MIN_PRE   = 2;           // 60 = 4 * 15
    localparam int MIN_POST  = 23;
    localparam int MIN_RCP_W = 20;
    localparam logic [MIN_RCP_W-1:0] MIN_RCP = 20'd559241;

    localparam int DAY_PRE   = 7;           // 86400 = 128 * 675
    localparam int DAY_POST  = 24;
    localparam int DAY_RCP_W = 15;
    localparam logic [DAY_RCP_W-1:0] DAY_RCP = 15'd24856;

    localparam int HTOT_W = 10;             // total hours stay below 583
    localparam int MTOT_W = 16;             // total minutes stay below 34953
    localparam int DAYS_W = 5;              // total days stay below 25

    typedef struct packed {
        logic               valid;
        logic               synced;
        logic [TICKS_W-1:0] ticks;
    } rtk_stage_t;

endpackage

`default_nettype wire

/* rtl/rtk_if.sv */
// ----------------------------------------------------------------------------
// RTC tick keeper channels
// Valid/ready interfaces for input items, result items and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtk_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [rtk_pkg::SAMPLE_W-1:0] counter_sample;
    logic [rtk_pkg::HOURS_W-1:0]  sync_hours;
    logic [rtk_pkg::MINUTES_W-1:0] sync_minutes;
    logic [rtk_pkg::SECONDS_W-1:0] sync_seconds;

    modport source (output valid, action, counter_sample, sync_hours, sync_minutes,
                    sync_seconds, input ready);
    modport sink (input valid, action, counter_sample, sync_hours, sync_minutes,
                  sync_seconds, output ready);
endinterface

interface rtk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rtk_pkg::TICKS_W-1:0]   system_ticks;
    logic [rtk_pkg::TOTAL_W-1:0]   total_seconds;
    logic [rtk_pkg::HOURS_W-1:0]   hour_of_day;
    logic [rtk_pkg::MINUTES_W-1:0] minute_of_hour;
    logic [rtk_pkg::SECONDS_W-1:0] second_of_minute;
    logic                          time_valid;

    modport source (output valid, system_ticks, total_seconds, hour_of_day,
                    minute_of_hour, second_of_minute, time_valid, input ready);
    modport sink (input valid, system_ticks, total_seconds, hour_of_day,
                  minute_of_hour, second_of_minute, time_valid, output ready);
endinterface

interface rtk_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rtk_pkg::COMP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/rtc_tick_time_of_day_keeper_top.sv */
// ----------------------------------------------------------------------------
// RTC tick time-of-day keeper
// Keeps a 32-bit tick count from RTC counter samples and sync items and
// reports it as ticks, seconds and time of day.
// ----------------------------------------------------------------------------
//  Channel  Role   Contents
//  req      sink   action, counter_sample, sync_hours, sync_minutes, sync_seconds
//  rsp      source system_ticks, total_seconds, hour/minute/second, time_valid
//  cfg      sink   travel_compensation_s (8 bits)
//
// One item per cycle is accepted unless results stall; each gives one result item.
// The tick count register is updated at accept, and the time split sits
// between it and the output register. Reset clears the tick count, the
// counter reference and the sync flag, and sets the compensation to 4 s.
// A stalled result holds the output register and then the staged count;
// input is refused only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_tick_time_of_day_keeper_top #(
    parameter int COUNTER_BITS = 24
) (
    input  wire       clk,
    input  wire       rst_n,
    rtk_req_if.sink   req,
    rtk_rsp_if.source rsp,
    rtk_cfg_if.sink   cfg
);

    rtk_pkg::rtk_stage_t stage;
    logic                take;

    rtk_accum #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .take  (take),
        .stage (stage)
    );

    rtk_split u_split (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

/* rtl/rtk_accum.sv */
// ----------------------------------------------------------------------------
// RTC tick accumulator
// Holds the tick count, the counter reference and the sync flag; the tick
// count register doubles as the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtk_accum #(
    parameter int COUNTER_BITS = 24
) (
    input  wire                   clk,
    input  wire                   rst_n,
    rtk_req_if.sink               req,
    rtk_cfg_if.sink               cfg,
    input  wire                   take,
    output rtk_pkg::rtk_stage_t   stage
);

    localparam int TW = rtk_pkg::TICKS_W;
    localparam int SW = rtk_pkg::SYNC_SECS_W;

    logic [TW-1:0]              acc_reg, acc_next;
    logic [COUNTER_BITS-1:0]    prev_reg;
    logic                       synced_reg;
    logic                       s1_valid_reg;
    logic [rtk_pkg::COMP_W-1:0] comp_reg;

    logic                       accept;
    logic [TW-1:0]              sample_wide;
    logic [COUNTER_BITS-1:0]    sample;
    logic [COUNTER_BITS-1:0]    delta;
    logic [SW-1:0]              sync_secs;
    logic [TW-1:0]              sync_ticks;

    assign req.ready = !s1_valid_reg || take;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    // The counter is narrowed or widened to its configured width.
    assign sample_wide = TW'(req.counter_sample);
    assign sample      = sample_wide[COUNTER_BITS-1:0];
    assign delta       = sample - prev_reg;

    assign sync_secs = SW'(req.sync_hours) * SW'(rtk_pkg::SECS_PER_HOUR)
                     + SW'(req.sync_minutes) * SW'(rtk_pkg::SECS_PER_MIN)
                     + SW'(req.sync_seconds) + SW'(comp_reg);
    assign sync_ticks = TW'(sync_secs) << rtk_pkg::TICK_SHIFT;

    always_comb
    begin
        case (req.action)
            rtk_pkg::ACT_SYNC:   acc_next = sync_ticks;
            rtk_pkg::ACT_SAMPLE: acc_next = acc_reg + TW'(delta);
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            prev_reg     <= '0;
            synced_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            comp_reg     <= rtk_pkg::COMP_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                comp_reg <= cfg.data;
            end
            if (accept)
            begin
                acc_reg      <= acc_next;
                prev_reg     <= sample;
                s1_valid_reg <= 1'b1;
                if (req.action == rtk_pkg::ACT_SYNC)
                begin
                    synced_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign stage.valid  = s1_valid_reg;
    assign stage.synced = synced_reg;
    assign stage.ticks  = acc_reg;

    // Once synced, the time stays valid until reset.
    assert property (@(posedge clk) disable iff (!rst_n) synced_reg |=> synced_reg)
        else $error("sync flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.action == rtk_pkg::ACT_SYNC) |=> synced_reg)
        else $error("sync item did not mark the time valid");

    // A staged item that is not taken must stay staged with the same count.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !take |=> s1_valid_reg && (acc_reg == $past(acc_reg)))
        else $error("staged item lost or changed while stalled");

endmodule

`default_nettype wire

/* rtl/rtk_split.sv */
// ----------------------------------------------------------------------------
// RTC time splitter
// Breaks the staged tick count into seconds, hours, minutes and seconds of
// minute, and holds the result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtk_split (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rtk_pkg::rtk_stage_t stage,
    output logic                take,
    rtk_rsp_if.source           rsp
);

    localparam int SW  = rtk_pkg::SECS_W;
    localparam int HXW = SW - rtk_pkg::HOUR_PRE;
    localparam int MXW = SW - rtk_pkg::MIN_PRE;
    localparam int DXW = SW - rtk_pkg::DAY_PRE;
    localparam int HPW = HXW + rtk_pkg::HOUR_RCP_W;
    localparam int MPW = MXW + rtk_pkg::MIN_RCP_W;
    localparam int DPW = DXW + rtk_pkg::DAY_RCP_W;
    localparam int HTW = rtk_pkg::HTOT_W;
    localparam int MTW = rtk_pkg::MTOT_W;
    localparam int DW  = rtk_pkg::DAYS_W;

    logic [SW-1:0]  secs;
    logic [HPW-1:0] hour_prod;
    logic [MPW-1:0] min_prod;
    logic [DPW-1:0] day_prod;
    logic [HTW-1:0] hours_total;
    logic [MTW-1:0] mins_total;
    logic [DW-1:0]  days_total;
    logic [SW-1:0]  sec_rem;
    logic [MTW-1:0] min_rem;
    logic [HTW-1:0] hour_rem;

    logic                          out_valid_reg;
    logic [rtk_pkg::TICKS_W-1:0]   ticks_reg;
    logic [rtk_pkg::TOTAL_W-1:0]   total_reg;
    logic [rtk_pkg::HOURS_W-1:0]   hour_reg, hour_next;
    logic [rtk_pkg::MINUTES_W-1:0] minute_reg, minute_next;
    logic [rtk_pkg::SECONDS_W-1:0] second_reg, second_next;
    logic                          tvalid_reg;

    assign secs = stage.ticks[rtk_pkg::TICKS_W-1:rtk_pkg::TICK_SHIFT];

    // The three quotients come straight from the second count, side by side.
    assign hour_prod = HPW'(secs[SW-1:rtk_pkg::HOUR_PRE]) * HPW'(rtk_pkg::HOUR_RCP);
    assign min_prod  = MPW'(secs[SW-1:rtk_pkg::MIN_PRE]) * MPW'(rtk_pkg::MIN_RCP);
    assign day_prod  = DPW'(secs[SW-1:rtk_pkg::DAY_PRE]) * DPW'(rtk_pkg::DAY_RCP);

    assign hours_total = HTW'(hour_prod >> rtk_pkg::HOUR_POST);
    assign mins_total  = MTW'(min_prod >> rtk_pkg::MIN_POST);
    assign days_total  = DW'(day_prod >> rtk_pkg::DAY_POST);

    // Remainders use shift-and-subtract products: x*60 = x*64 - x*4, x*24 = x*16 + x*8.
    assign sec_rem  = secs - ((SW'(mins_total) << 6) - (SW'(mins_total) << 2));
    assign min_rem  = mins_total - ((MTW'(hours_total) << 6) - (MTW'(hours_total) << 2));
    assign hour_rem = hours_total - ((HTW'(days_total) << 4) + (HTW'(days_total) << 3));

    assign second_next = sec_rem[rtk_pkg::SECONDS_W-1:0];
    assign minute_next = min_rem[rtk_pkg::MINUTES_W-1:0];
    assign hour_next   = hour_rem[rtk_pkg::HOURS_W-1:0];

    assign take = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stage.valid)
        begin
            ticks_reg  <= stage.ticks;
            total_reg  <= secs[rtk_pkg::TOTAL_W-1:0];
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            tvalid_reg <= stage.synced;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.system_ticks     = ticks_reg;
    assign rsp.total_seconds    = total_reg;
    assign rsp.hour_of_day      = hour_reg;
    assign rsp.minute_of_hour   = minute_reg;
    assign rsp.second_of_minute = second_reg;
    assign rsp.time_valid       = tvalid_reg;

    // The reciprocal quotients must leave remainders inside their clock ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hour_reg < 5'd24) && (minute_reg < 6'd60) && (second_reg < 6'd60))
        else $error("time field out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (total_reg == ticks_reg[rtk_pkg::TICK_SHIFT+rtk_pkg::TOTAL_W-1:rtk_pkg::TICK_SHIFT]))
        else $error("total seconds do not match the tick count");

    assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && take |=> out_valid_reg)
        else $error("taken item did not reach the output register");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTC tick time-of-day keeper testbench
// Drives sync and counter sample items through the request channel, predicts
// the tick count and the time-of-day split for each one, and compares every
// result item field by field while both sides idle and stall in phases.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int HOURS_PER_DAY = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic                          action;
        logic [rtk_pkg::SAMPLE_W-1:0]  counter_sample;
        logic [rtk_pkg::HOURS_W-1:0]   hours;
        logic [rtk_pkg::MINUTES_W-1:0] minutes;
        logic [rtk_pkg::SECONDS_W-1:0] seconds;
    } rtc_item_t;

    typedef struct packed {
        logic [rtk_pkg::TICKS_W-1:0]   ticks;
        logic [rtk_pkg::TOTAL_W-1:0]   total_s;
        logic [rtk_pkg::HOURS_W-1:0]   hour;
        logic [rtk_pkg::MINUTES_W-1:0] minute;
        logic [rtk_pkg::SECONDS_W-1:0] second;
        logic                          valid_time;
    } time_report_t;

    logic clk = 1'b0;
    logic rst_n;

    rtk_req_if req();
    rtk_rsp_if rsp();
    rtk_cfg_if cfg();

    rtc_tick_time_of_day_keeper_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #1 clk = ~clk;

    // Predicted keeper state.
    logic [rtk_pkg::COMP_W-1:0]   travel_comp_s = rtk_pkg::COMP_RESET;
    logic [rtk_pkg::SAMPLE_W-1:0] ref_sample    = '0;
    logic [rtk_pkg::TICKS_W-1:0]  tick_count    = '0;
    logic                         synced        = 1'b0;

    time_report_t                 expected_reports[$];
    int                           mismatches  = 0;
    int                           cycle_count = 0;
    int                           src_idle_pct  = 0;
    int                           sink_stall_pct = 0;
    logic [rtk_pkg::SAMPLE_W-1:0] rtc_now = '0;

    function automatic time_report_t advance_time(rtc_item_t it);
        logic [31:0]                  secs;
        logic [rtk_pkg::SAMPLE_W-1:0] delta;
        time_report_t                 r;
        if (it.action == rtk_pkg::ACT_SYNC) begin
            secs = it.hours * rtk_pkg::SECS_PER_HOUR + it.minutes * rtk_pkg::SECS_PER_MIN
                   + it.seconds + 32'(travel_comp_s);
            tick_count = secs << rtk_pkg::TICK_SHIFT;
            ref_sample = it.counter_sample;
            synced     = 1'b1;
        end
        else begin
            // Difference taken at counter width, so a wrap through zero counts.
            delta      = it.counter_sample - ref_sample;
            tick_count = tick_count + rtk_pkg::TICKS_W'(delta);
            ref_sample = it.counter_sample;
        end
        secs         = tick_count >> rtk_pkg::TICK_SHIFT;
        r.ticks      = tick_count;
        r.total_s    = secs[rtk_pkg::TOTAL_W-1:0];
        r.hour       = rtk_pkg::HOURS_W'((secs / rtk_pkg::SECS_PER_HOUR) % HOURS_PER_DAY);
        r.minute     = rtk_pkg::MINUTES_W'((secs % rtk_pkg::SECS_PER_HOUR)
                                           / rtk_pkg::SECS_PER_MIN);
        r.second     = rtk_pkg::SECONDS_W'(secs % rtk_pkg::SECS_PER_MIN);
        r.valid_time = synced;
        return r;
    endfunction

    function automatic rtc_item_t make_sync(int h, int m, int s,
                                            logic [rtk_pkg::SAMPLE_W-1:0] smp);
        rtc_item_t it;
        it.action         = rtk_pkg::ACT_SYNC;
        it.counter_sample = smp;
        it.hours          = rtk_pkg::HOURS_W'(h);
        it.minutes        = rtk_pkg::MINUTES_W'(m);
        it.seconds        = rtk_pkg::SECONDS_W'(s);
        return it;
    endfunction

    // Sync fields of a sample item are ignored by the block, so they carry noise.
    function automatic rtc_item_t make_sample(logic [rtk_pkg::SAMPLE_W-1:0] smp);
        rtc_item_t it;
        it.action         = rtk_pkg::ACT_SAMPLE;
        it.counter_sample = smp;
        it.hours          = rtk_pkg::HOURS_W'($urandom);
        it.minutes        = rtk_pkg::MINUTES_W'($urandom);
        it.seconds        = rtk_pkg::SECONDS_W'($urandom);
        return it;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(rtc_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.action         <= it.action;
        req.counter_sample <= it.counter_sample;
        req.sync_hours     <= it.hours;
        req.sync_minutes   <= it.minutes;
        req.sync_seconds   <= it.seconds;
        do
            @(posedge clk);
        while (!req.ready);
        rtc_now = it.counter_sample;
        expected_reports.push_back(advance_time(it));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_comp(logic [rtk_pkg::COMP_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        travel_comp_s = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_sample_before_sync();
        send_item(make_sample(24'h000010));
        send_item(make_sample(24'hFFFFFF));
        send_item(make_sample(24'h000005));
        send_item(make_sample(24'h000005));
    endtask

    task automatic test_sync_limits();
        write_comp(8'd0);
        send_item(make_sync(0, 0, 0, 24'h000000));
        send_item(make_sample(24'h000800));
        write_comp(8'd255);
        send_item(make_sync(23, 59, 59, 24'hFFFFFF));
        send_item(make_sample(24'h000000));
        // Out-of-range received time is used as given.
        send_item(make_sync(31, 63, 63, 24'h123456));
        send_item(make_sample(24'h1A3456));
        send_item(make_sync(21, 42, 21, 24'hAAAAAA));
        send_item(make_sync(10, 21, 42, 24'h555555));
    endtask

    task automatic test_counter_wrap();
        send_item(make_sync(12, 30, 0, 24'hFFFFF0));
        send_item(make_sample(24'h00000F));
        send_item(make_sample(24'hFFFFFF));
        send_item(make_sample(24'h000000));
        send_item(make_sample(24'h000000));
        send_item(make_sample(24'h7FFFFF));
    endtask

    // Near-full counter deltas push the tick count past 2^32.
    task automatic test_tick_overflow();
        send_item(make_sync(23, 59, 59, rtk_pkg::SAMPLE_W'($urandom)));
        repeat (270)
            send_item(make_sample(rtc_now
                + rtk_pkg::SAMPLE_W'($urandom_range(24'hFFFFFF, 24'hF00000))));
    endtask

    task automatic send_random_items(int n);
        int                           r;
        logic [rtk_pkg::SAMPLE_W-1:0] delta;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(make_sync($urandom_range(23), $urandom_range(59),
                                    $urandom_range(59), rtk_pkg::SAMPLE_W'($urandom)));
            end
            else if (r < 12) begin
                send_item(make_sync($urandom_range(31), $urandom_range(63),
                                    $urandom_range(63), rtk_pkg::SAMPLE_W'($urandom)));
            end
            else if (r < 85) begin
                case ($urandom_range(3))
                    0: delta = rtk_pkg::SAMPLE_W'($urandom_range(15));
                    1: delta = rtk_pkg::SAMPLE_W'($urandom_range(4095));
                    2: delta = rtk_pkg::SAMPLE_W'($urandom_range(1 << 20));
                    default: delta = rtk_pkg::SAMPLE_W'($urandom);
                endcase
                send_item(make_sample(rtc_now + delta));
            end
            else begin
                send_item(make_sample(rtk_pkg::SAMPLE_W'($urandom)));
            end
        end
    endtask

    task automatic test_random_phase(int src_pct, int sink_pct,
                                     logic [rtk_pkg::COMP_W-1:0] comp, int n);
        write_comp(comp);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        send_random_items(n);
        wait_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk) begin
        time_report_t want;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result item, ticks %0d", $time, rsp.system_ticks);
                mismatches++;
            end
            else begin
                want = expected_reports.pop_front();
                compare_field("system_ticks", want.ticks, rsp.system_ticks);
                compare_field("total_seconds", want.total_s, rsp.total_seconds);
                compare_field("hour_of_day", want.hour, rsp.hour_of_day);
                compare_field("minute_of_hour", want.minute, rsp.minute_of_hour);
                compare_field("second_of_minute", want.second, rsp.second_of_minute);
                compare_field("time_valid", want.valid_time, rsp.time_valid);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.action         = rtk_pkg::ACT_SAMPLE;
        req.counter_sample = '0;
        req.sync_hours     = '0;
        req.sync_minutes   = '0;
        req.sync_seconds   = '0;
        cfg.valid          = 1'b0;
        cfg.data           = '0;
        rsp.ready          = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_sample_before_sync();
        test_sync_limits();
        test_counter_wrap();
        test_tick_overflow();
        test_random_phase(0, 0, 8'd0, 210);
        test_random_phase(64, 0, 8'd255, 210);
        test_random_phase(0, 64, rtk_pkg::COMP_W'($urandom), 210);
        test_random_phase(19, 19, rtk_pkg::COMP_RESET, 210);

        wait_idle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* rtc_tick_time_of_day_keeper_top.f */
rtl/rtk_pkg.sv
rtl/rtk_if.sv
rtl/rtk_accum.sv
rtl/rtk_split.sv
rtl/rtc_tick_time_of_day_keeper_top.sv
tb/tb_top.sv
